// File: hdl/nmea_sentence_checker_unit_defines.svh
// Assertion macros for the sentence checker.
// The clock is clk and the reset is arst_n at the point of use.
`ifndef NMEA_SENTENCE_CHECKER_UNIT_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nsc assertion failed");
`define NSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nsc assertion failed");
`else
`define NSC_ASSERT_NOW(lbl, ante, cons)
`define NSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/nsc_pkg.sv
package nsc_pkg;

	localparam int MAX_LEN = 128;
	localparam int LEN_W = 8;
	localparam int COMMA_W = 6;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] LETTER_G = 8'h47;
	localparam logic [7:0] LETTER_A = 8'h41;
	localparam logic [LEN_W-1:0] POS_THIRD = LEN_W'(3);
	localparam logic [LEN_W-1:0] POS_FOURTH = LEN_W'(4);
	localparam logic [COMMA_W-1:0] COMMA_MAX = '1;

	typedef enum logic [0:0] {
		CFG_TYPE_THIRD = 1'b0,
		CFG_TYPE_FOURTH = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic checksum_ok;
		logic type_match;
		logic star_found;
		logic too_long;
		logic [LEN_W-1:0] body_length;
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
		logic [COMMA_W-1:0] comma_count;
	} verdict_t;

	typedef struct packed {
		logic in_sentence;
		logic [7:0] running_xor;
		logic star_seen;
		logic [1:0] hex_taken;
		logic [7:0] received_acc;
		logic [LEN_W-1:0] length_count;
		logic [1:0] type_flags;
		logic [COMMA_W-1:0] commas_seen;
		logic overflowed;
	} sent_state_t;

	// hex-ish digit decode; anything else passes raw
	function automatic logic [7:0] decode_char(input logic [7:0] c);
		logic [7:0] d;
		if (c >= 8'h41 && c <= 8'h5A) d = c - 8'h37;
		else if (c >= 8'h61 && c <= 8'h7A) d = c - 8'h57;
		else if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
		else d = c;
		return d;
	endfunction

endpackage

// File: hdl/nsc_input_reg.sv
module nsc_input_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import nsc_pkg::*;

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end
endmodule

// File: hdl/nsc_parser.sv
module nsc_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_s1,
	input  logic [7:0]        letter_third,
	input  logic [7:0]        letter_fourth,
	output logic              emit,
	output nsc_pkg::verdict_t verdict
);
	import nsc_pkg::*;

	sent_state_t st_q;
	sent_state_t st_d;
	logic star_ok;

	always_comb begin
		star_ok = st_q.star_seen && (st_q.hex_taken == 2'd2);
		verdict.checksum_ok = star_ok && !st_q.overflowed
			&& (st_q.running_xor == st_q.received_acc);
		verdict.type_match = (st_q.type_flags == 2'b11);
		verdict.star_found = star_ok;
		verdict.too_long = st_q.overflowed;
		verdict.body_length = st_q.length_count;
		verdict.computed_sum = st_q.running_xor;
		verdict.received_sum = st_q.received_acc;
		verdict.comma_count = st_q.commas_seen;
	end

	always_comb begin
		st_d = st_q;
		emit = 1'b0;
		if (step) begin
			if (!st_q.in_sentence) begin
				if (byte_s1 == CH_DOLLAR) begin
					st_d = '0;
					st_d.in_sentence = 1'b1;
				end
			end else if (byte_s1 == CH_CR) begin
				emit = 1'b1;
				st_d = '0;
			end else if (st_q.length_count >= LEN_W'(MAX_LEN)) begin
				st_d.overflowed = 1'b1;
			end else begin
				st_d.length_count = st_q.length_count + 1'b1;
				if (st_q.length_count == POS_THIRD && byte_s1 == letter_third)
					st_d.type_flags[0] = 1'b1;
				if (st_q.length_count == POS_FOURTH && byte_s1 == letter_fourth)
					st_d.type_flags[1] = 1'b1;
				if (byte_s1 == CH_COMMA && st_q.commas_seen != COMMA_MAX)
					st_d.commas_seen = st_q.commas_seen + 1'b1;
				if (!st_q.star_seen) begin
					if (byte_s1 == CH_STAR) st_d.star_seen = 1'b1;
					else st_d.running_xor = st_q.running_xor ^ byte_s1;
				end else if (st_q.hex_taken < 2'd2) begin
					st_d.received_acc = {st_q.received_acc[3:0], 4'h0}
						+ decode_char(byte_s1);
					st_d.hex_taken = st_q.hex_taken + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= st_d;
		end
	end
endmodule

// File: hdl/nsc_result_reg.sv
module nsc_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              emit,
	input  nsc_pkg::verdict_t verdict,
	output logic              advance,
	input  logic              out_stall,
	output logic              out_valid,
	output nsc_pkg::verdict_t verdict_q
);
	import nsc_pkg::*;

	logic load;

	assign advance = !out_valid || !out_stall;
	assign load = advance && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q <= verdict;
		end
	end
endmodule

// File: hdl/nmea_sentence_checker_unit.sv
// NMEA 0183 sentence checker: one received byte per beat, one verdict per sentence.
// A CR beat is registered in the input register, its verdict in the output register.
// Throughput: one byte per cycle barring input stalls; one parser step per byte.
// Input stalls only while a verdict waits at a stalled output register.
// Reset (arst_n low, asynchronous): hunting for '$', all sentence state cleared,
// type letters back to 'G' and 'A', both channels empty.
`include "nmea_sentence_checker_unit_defines.svh"

module nmea_sentence_checker_unit (
	input  logic       clk,
	input  logic       arst_n,
	// byte channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// verdict channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       checksum_ok,
	output logic       type_match,
	output logic       star_found,
	output logic       too_long,
	output logic [7:0] body_length,
	output logic [7:0] computed_sum,
	output logic [7:0] received_sum,
	output logic [5:0] comma_count,
	// register writes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import nsc_pkg::*;

	logic [7:0] letter_third_q;
	logic [7:0] letter_fourth_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       emit;
	verdict_t   verdict;
	verdict_t   verdict_q;

	// Config writes are always taken; software writes only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_third_q <= LETTER_G;
			letter_fourth_q <= LETTER_A;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TYPE_THIRD: letter_third_q <= cfg_data;
				CFG_TYPE_FOURTH: letter_fourth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: input byte register. It empties whenever the output side can
	// take a verdict, so a byte follows every cycle while the output is not stalled.
	nsc_input_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Sentence state: hunt, XOR, star/hex decode, length, commas, type letters.
	// Verdict is formed from current state when a CR arrives.
	nsc_parser u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (valid_s1 && advance),
		.byte_s1       (byte_s1),
		.letter_third  (letter_third_q),
		.letter_fourth (letter_fourth_q),
		.emit          (emit),
		.verdict       (verdict)
	);

	// Output register; doubles as the back-pressure point for the pipe.
	nsc_result_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.verdict   (verdict),
		.advance   (advance),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.verdict_q (verdict_q)
	);

	assign checksum_ok = verdict_q.checksum_ok;
	assign type_match = verdict_q.type_match;
	assign star_found = verdict_q.star_found;
	assign too_long = verdict_q.too_long;
	assign body_length = verdict_q.body_length;
	assign computed_sum = verdict_q.computed_sum;
	assign received_sum = verdict_q.received_sum;
	assign comma_count = verdict_q.comma_count;

	// A passing checksum needs the star, both digits, no overflow and equal sums.
	`NSC_ASSERT_NOW(a_ok_consistent, out_valid && checksum_ok,
		star_found && !too_long && (computed_sum == received_sum))
	// Stored length never passes the limit.
	`NSC_ASSERT_NOW(a_len_bound, out_valid, body_length <= LEN_W'(MAX_LEN))
	// An overflowed body always filled the buffer first.
	`NSC_ASSERT_NOW(a_overflow_full, out_valid && too_long,
		body_length == LEN_W'(MAX_LEN))
	// A CR reaching the parser mid-sentence with room downstream lands a verdict.
	`NSC_ASSERT_NEXT(a_emit_lands, emit && advance, out_valid)
endmodule

// File: tb/nmea_sentence_checker_unit_test.sv
module nmea_sentence_checker_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import nsc_pkg::*;

	// cycles to sit out after the last verdict, before a register write or the end
	localparam int DRAIN_CYCLES = 4;

	// Directed stimulus: one row per byte. Rows that end a sentence carry a verdict
	// typed in by hand; everything else goes through the predictor.
	typedef struct packed {
		logic [7:0] ch;
		logic       pinned;
		verdict_t   verdict;
	} dir_row_t;

	localparam verdict_t NO_PIN = '0;
	// "GPGGA" with checksum 0x56, both type letters at their reset values
	localparam verdict_t V_GPGGA = {1'b1, 1'b1, 1'b1, 1'b0, 8'd8, 8'h56, 8'h56, 6'd0};
	// "$" straight into CR: empty body, everything zero
	localparam verdict_t V_EMPTY = '0;
	// star and a single lowercase digit, no second digit
	localparam verdict_t V_ONE_DIGIT = {1'b0, 1'b0, 1'b0, 1'b0, 8'd2, 8'h00, 8'h23, 6'd0};
	// dollar stored as body byte, then a digit and a raw non-hex character
	localparam verdict_t V_RAW_DIGIT = {1'b0, 1'b0, 1'b1, 1'b0, 8'd5, 8'h08, 8'h7E, 6'd1};

	localparam dir_row_t DIR_ROWS [25] = '{
		// field extremes while hunting: dropped, no verdict
		{8'h00, 1'b0, NO_PIN},
		{8'hFF, 1'b0, NO_PIN},
		// clean sentence, numeric checksum digits
		{CH_DOLLAR, 1'b0, NO_PIN},
		{"G", 1'b0, NO_PIN},
		{"P", 1'b0, NO_PIN},
		{"G", 1'b0, NO_PIN},
		{"G", 1'b0, NO_PIN},
		{"A", 1'b0, NO_PIN},
		{CH_STAR, 1'b0, NO_PIN},
		{"5", 1'b0, NO_PIN},
		{"6", 1'b0, NO_PIN},
		{CH_CR, 1'b1, V_GPGGA},
		// empty body
		{CH_DOLLAR, 1'b0, NO_PIN},
		{CH_CR, 1'b1, V_EMPTY},
		// too few checksum characters
		{CH_DOLLAR, 1'b0, NO_PIN},
		{CH_STAR, 1'b0, NO_PIN},
		{"z", 1'b0, NO_PIN},
		{CH_CR, 1'b1, V_ONE_DIGIT},
		// dollar inside the body, comma, raw decode of '~'
		{CH_DOLLAR, 1'b0, NO_PIN},
		{CH_COMMA, 1'b0, NO_PIN},
		{CH_DOLLAR, 1'b0, NO_PIN},
		{CH_STAR, 1'b0, NO_PIN},
		{"0", 1'b0, NO_PIN},
		{"~", 1'b0, NO_PIN},
		{CH_CR, 1'b1, V_RAW_DIGIT}
	};

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       checksum_ok;
	logic       type_match;
	logic       star_found;
	logic       too_long;
	logic [7:0] body_length;
	logic [7:0] computed_sum;
	logic [7:0] received_sum;
	logic [5:0] comma_count;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	// travels with rx_byte: use a hand-typed verdict instead of the predicted one
	logic       pin_on = 1'b0;
	verdict_t   pin_verdict = '0;

	nmea_sentence_checker_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.checksum_ok  (checksum_ok),
		.type_match   (type_match),
		.star_found   (star_found),
		.too_long     (too_long),
		.body_length  (body_length),
		.computed_sum (computed_sum),
		.received_sum (received_sum),
		.comma_count  (comma_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sentence predictor: its own copy of the letters and parser state
	// ---------------------------------------------------------------
	logic [7:0] letter3_cfg = LETTER_G;
	logic [7:0] letter4_cfg = LETTER_A;
	bit         in_body = 1'b0;
	logic [7:0] xor_acc = '0;
	logic [7:0] sum_acc = '0;
	logic [7:0] body_len = '0;
	bit         star_hit = 1'b0;
	bit         overrun = 1'b0;
	int         digits_taken = 0;
	logic [1:0] letter_hits = '0;
	logic [5:0] commas = '0;

	verdict_t   verdicts [$];   // predicted verdicts, oldest first
	int         errors = 0;

	function automatic void clear_body();
		xor_acc = '0;
		sum_acc = '0;
		body_len = '0;
		star_hit = 1'b0;
		overrun = 1'b0;
		digits_taken = 0;
		letter_hits = '0;
		commas = '0;
	endfunction

	// checksum character to value; letters map past 9, anything else is raw
	function automatic logic [7:0] nibble_of(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return 8'(c - 8'h37);
		if (c >= "a" && c <= "z") return 8'(c - 8'h57);
		if (c >= "0" && c <= "9") return 8'(c - 8'h30);
		return c;
	endfunction

	// Feeds one accepted byte; returns 1 with the verdict when the byte ends a sentence.
	function automatic bit scan_byte(input logic [7:0] c, output verdict_t v);
		v = '0;
		if (!in_body) begin
			// hunting: only '$' matters
			if (c == CH_DOLLAR) begin
				clear_body();
				in_body = 1'b1;
			end
			return 1'b0;
		end
		if (c != CH_CR) begin
			if (body_len >= MAX_LEN) begin
				// past the end of the buffer: dropped, only flagged
				overrun = 1'b1;
			end else begin
				if (body_len == POS_THIRD && c == letter3_cfg) letter_hits[0] = 1'b1;
				if (body_len == POS_FOURTH && c == letter4_cfg) letter_hits[1] = 1'b1;
				body_len = body_len + 8'd1;
				if (c == CH_COMMA && commas != COMMA_MAX) commas = commas + 6'd1;
				if (!star_hit) begin
					if (c == CH_STAR) star_hit = 1'b1;
					else xor_acc = xor_acc ^ c;
				end else if (digits_taken < 2) begin
					sum_acc = 8'((sum_acc << 4) + nibble_of(c));
					digits_taken++;
				end
			end
			return 1'b0;
		end
		v.star_found = star_hit && digits_taken == 2;
		v.checksum_ok = v.star_found && !overrun && xor_acc == sum_acc;
		v.type_match = letter_hits == 2'b11;
		v.too_long = overrun;
		v.body_length = body_len;
		v.computed_sum = xor_acc;
		v.received_sum = sum_acc;
		v.comma_count = commas;
		in_body = 1'b0;
		clear_body();
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// Monitor: everything is sampled at the rising edge, before the drivers' updates land.
	always @(posedge clk) begin
		verdict_t pred;
		verdict_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TYPE_THIRD) letter3_cfg = cfg_data;
				else letter4_cfg = cfg_data;
			end
			if (in_valid && !in_stall && scan_byte(rx_byte, pred))
				verdicts.push_back(pin_on ? pin_verdict : pred);
			if (out_valid && !out_stall) begin
				if (verdicts.size() == 0) begin
					$error("verdict beat with no sentence pending");
					errors++;
				end else begin
					want = verdicts.pop_front();
					check_field("checksum_ok", want.checksum_ok, checksum_ok);
					check_field("type_match", want.type_match, type_match);
					check_field("star_found", want.star_found, star_found);
					check_field("too_long", want.too_long, too_long);
					check_field("body_length", want.body_length, body_length);
					check_field("computed_sum", want.computed_sum, computed_sum);
					check_field("received_sum", want.received_sum, received_sum);
					check_field("comma_count", want.comma_count, comma_count);
				end
			end
		end
	end

	// Receiver: alternates open and stalled runs; open runs are sometimes long,
	// stalled runs are mostly short with the odd long one.
	int stall_left = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			if (out_stall) begin
				out_stall <= 1'b0;
				stall_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
			end else begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 30 : 4);
			end
		end else begin
			stall_left--;
		end
	end

	// ---------------------------------------------------------------
	// Byte sender
	// ---------------------------------------------------------------
	int burst_left = 0;
	bit gaps_on = 1'b1;

	// Sends one beat; bursts of random length, with random gaps in between while gaps_on is set.
	task automatic send_byte(input logic [7:0] c, input logic pin, input verdict_t v);
		int gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gaps_on && $urandom_range(0, 9) == 0) gap = $urandom_range(7, 25);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte <= c;
		pin_on <= pin;
		pin_verdict <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// Holds off the sender until every predicted verdict has been seen.
	task automatic drain_verdicts();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both letters back to back; valid stays up between the two beats.
	task automatic load_letters(input logic [7:0] third, input logic [7:0] fourth);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TYPE_THIRD;
		cfg_data <= third;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_TYPE_FOURTH;
		cfg_data <= fourth;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Random sentence builder
	// ---------------------------------------------------------------
	logic [7:0] line_bytes [$];
	int         long_left = 6;   // sentences around the buffer limit still allowed

	function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
		if (n < 4'd10) return 8'("0" + n);
		return 8'((lower ? "a" : "A") + n - 10);
	endfunction

	// printable field text: '-' through 'z', never '*', '$', ',' or CR
	function automatic logic [7:0] field_char();
		return 8'($urandom_range(8'h2D, 8'h7A));
	endfunction

	// Star and two checksum characters over the body built so far; a wrong
	// checksum is either a random value or two arbitrary characters.
	function automatic void append_checksum(input bit correct);
		logic [7:0] s;
		s = '0;
		for (int i = 1; i < line_bytes.size(); i++) s = s ^ line_bytes[i];
		if (!correct) s = 8'($urandom_range(0, 255));
		line_bytes.push_back(CH_STAR);
		if (correct || $urandom_range(0, 1) == 0) begin
			line_bytes.push_back(hex_digit(s[7:4], $urandom_range(0, 1)));
			line_bytes.push_back(hex_digit(s[3:0], $urandom_range(0, 1)));
		end else begin
			line_bytes.push_back(field_char());
			line_bytes.push_back(field_char());
		end
	endfunction

	function automatic logic [7:0] any_but_cr();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		return (c == CH_CR) ? CH_COMMA : c;
	endfunction

	function automatic void compose_sentence(output bit noise_only);
		int kind;
		int n;
		logic [7:0] c;
		line_bytes.delete();
		noise_only = 1'b0;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			// line noise between sentences, no '$' so it stays ignored
			noise_only = 1'b1;
			n = $urandom_range(1, 8);
			repeat (n) begin
				c = 8'($urandom_range(0, 255));
				line_bytes.push_back((c == CH_DOLLAR) ? 8'h00 : c);
			end
			return;
		end
		line_bytes.push_back(CH_DOLLAR);
		if (kind < 12 && long_left > 0) begin
			// around the buffer limit; comma-heavy so the comma count saturates
			long_left--;
			n = $urandom_range(MAX_LEN - 5, MAX_LEN + 5);
			repeat (n) line_bytes.push_back(($urandom_range(0, 4) < 3) ? CH_COMMA : field_char());
			append_checksum(1'b1);
		end else if (kind < 30) begin
			// broken: arbitrary bytes (CR, '$', '*' included), then a damaged tail or none
			n = $urandom_range(0, 24);
			repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
			case ($urandom_range(0, 3))
				1: line_bytes.push_back(CH_STAR);
				2: begin
					line_bytes.push_back(CH_STAR);
					line_bytes.push_back(field_char());
				end
				3: begin
					line_bytes.push_back(CH_STAR);
					append_checksum($urandom_range(0, 1));
				end
				default: ;
			endcase
		end else begin
			// well formed: talker, type letters (mostly the configured ones at
			// body characters 3 and 4), fields
			line_bytes.push_back(8'($urandom_range("A", "Z")));
			line_bytes.push_back(8'($urandom_range("A", "Z")));
			line_bytes.push_back(8'($urandom_range("A", "Z")));
			line_bytes.push_back(($urandom_range(0, 4) != 0) ? letter3_cfg : any_but_cr());
			line_bytes.push_back(($urandom_range(0, 4) != 0) ? letter4_cfg : any_but_cr());
			n = $urandom_range(0, 10);
			repeat (n) begin
				line_bytes.push_back(CH_COMMA);
				repeat ($urandom_range(0, 6)) line_bytes.push_back(field_char());
			end
			append_checksum($urandom_range(0, 9) != 0);
			// trailing junk after the checksum
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 3)) line_bytes.push_back(field_char());
		end
		line_bytes.push_back(CH_CR);
	endfunction

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int  counted;
		int  sentences;
		bit  noise_only;
		counted = 0;
		sentences = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part at the reset letters
		for (int i = 0; i < $size(DIR_ROWS); i++)
			send_byte(DIR_ROWS[i].ch, DIR_ROWS[i].pinned, DIR_ROWS[i].verdict);

		// random part: one letter setting per phase, block idle around each write
		for (int phase = 0; phase < 6; phase++) begin
			drain_verdicts();
			case (phase)
				1: load_letters("M", "C");
				2: load_letters(8'h00, 8'hFF);
				3: load_letters(8'hFF, 8'h00);
				4: load_letters(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				5: load_letters(LETTER_G, LETTER_A);
				default: ;
			endcase
			// one phase runs the sender flat out
			gaps_on = (phase != 2);
			while (counted < 170 * (phase + 1) || sentences < 8 * (phase + 1)) begin
				compose_sentence(noise_only);
				foreach (line_bytes[i]) send_byte(line_bytes[i], 1'b0, NO_PIN);
				if (!noise_only) begin
					counted += line_bytes.size();
					sentences++;
				end
			end
		end

		drain_verdicts();
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/nsc_pkg.sv
hdl/nsc_input_reg.sv
hdl/nsc_parser.sv
hdl/nsc_result_reg.sv
hdl/nmea_sentence_checker_unit.sv
tb/nmea_sentence_checker_unit_test.sv
